// ===== rtl/bdgd_pkg.sv =====
// Shared types and codes for the button debounce / gesture detector.
// No dependencies; imported by the top level and its checker.
package bdgd_pkg;

   typedef enum logic [1:0] {
      GESTURE_NONE   = 2'd0,
      GESTURE_CLICK  = 2'd1,
      GESTURE_LONG   = 2'd2,
      GESTURE_SECRET = 2'd3
   } gesture_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLICK_MAX     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECRET_WINDOW = 3'd3;

   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_RESET      = 16'd50;
   localparam logic [CSR_DATA_W-1:0] CLICK_MAX_RESET     = 16'd500;
   localparam logic [CSR_DATA_W-1:0] LONG_PRESS_RESET    = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] SECRET_WINDOW_RESET = 16'd1500;

   typedef struct packed {
      gesture_type gesture;
      logic        stable_pressed;
   } rsp_type;

endpackage

// ===== rtl/button_debounce_gesture_detector.sv =====
// Top level of the button debounce / gesture detector.
// Depends on bdgd_pkg for the gesture codes, register indexes and result type.

// One poll per req_ transfer, one result per poll, one poll per clock cycle
// sustained while rsp_ready keeps taking results. Each poll is evaluated in
// the cycle it is accepted: a handful of 32-bit modulo subtractions against
// the 16-bit thresholds update the debounce and gesture state, and the result
// lands in a two-entry output queue. The queue lets a poll be accepted while
// one result is still waiting on rsp_; req_ready drops only when both entries
// are full. A result appears on rsp_ the cycle after its poll when the queue
// was empty, later if an older result is still waiting. The csr_ port writes
// the four millisecond thresholds; write them only while the block is idle.
module button_debounce_gesture_detector
   import bdgd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_raw_pressed,
   input  logic [31:0]            req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_gesture,
   output logic                   rsp_stable_pressed,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CSR_DATA_W-1:0] debounce_ff, click_max_ff, long_press_ff, secret_window_ff;

   logic        last_raw_ff, last_raw_in;
   logic        debounced_ff, debounced_in;
   logic [31:0] stable_since_ff, stable_since_in;
   logic [31:0] press_start_ff, press_start_in;
   logic [31:0] long_release_ff, long_release_in;
   logic        long_release_valid_ff, long_release_valid_in;
   logic        long_fired_ff, long_fired_in;

   rsp_type     result;
   rsp_type     slot0_ff, slot1_ff;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  count_after_pop;
   logic        push, pop;

   logic [31:0] since_stable, since_release, since_press;
   logic        window_open, take_level, held;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_RESET;
         click_max_ff     <= CLICK_MAX_RESET;
         long_press_ff    <= LONG_PRESS_RESET;
         secret_window_ff <= SECRET_WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE:      debounce_ff      <= csr_wdata;
            CSR_CLICK_MAX:     click_max_ff     <= csr_wdata;
            CSR_LONG_PRESS:    long_press_ff    <= csr_wdata;
            CSR_SECRET_WINDOW: secret_window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-poll evaluation
   always_comb begin
      last_raw_in           = req_raw_pressed;
      stable_since_in       = (req_raw_pressed != last_raw_ff) ? req_now_ms : stable_since_ff;
      debounced_in          = debounced_ff;
      press_start_in        = press_start_ff;
      long_release_in       = long_release_ff;
      long_fired_in         = long_fired_ff;
      result.gesture        = GESTURE_NONE;

      since_release = req_now_ms - long_release_ff;
      // a pending long-press release expires before anything else is decided
      window_open   = long_release_valid_ff &&
                      (since_release <= {16'd0, secret_window_ff});
      long_release_valid_in = window_open;

      since_stable = req_now_ms - stable_since_in;
      take_level   = (since_stable >= {16'd0, debounce_ff}) &&
                     (req_raw_pressed != debounced_ff);
      since_press  = req_now_ms - press_start_ff;

      if (take_level) begin
         debounced_in = req_raw_pressed;
         if (req_raw_pressed) begin
            press_start_in = req_now_ms;
            long_fired_in  = 1'b0;
         end else if (long_fired_ff) begin
            long_release_in       = req_now_ms;
            long_release_valid_in = 1'b1;
         end else if (since_press <= {16'd0, click_max_ff}) begin
            if (window_open) begin
               result.gesture        = GESTURE_SECRET;
               long_release_valid_in = 1'b0;
            end else begin
               result.gesture = GESTURE_CLICK;
            end
         end
      end

      // hold time measured from the press start as it stands after this poll
      held = (req_now_ms - press_start_in) >= {16'd0, long_press_ff};
      if (debounced_in && !long_fired_in && held) begin
         result.gesture = GESTURE_LONG;
         long_fired_in  = 1'b1;
      end

      result.stable_pressed = debounced_in;
   end

   assign push = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff           <= 1'b0;
         debounced_ff          <= 1'b0;
         stable_since_ff       <= 32'd0;
         press_start_ff        <= 32'd0;
         long_release_ff       <= 32'd0;
         long_release_valid_ff <= 1'b0;
         long_fired_ff         <= 1'b0;
      end else if (push) begin
         last_raw_ff           <= last_raw_in;
         debounced_ff          <= debounced_in;
         stable_since_ff       <= stable_since_in;
         press_start_ff        <= press_start_in;
         long_release_ff       <= long_release_in;
         long_release_valid_ff <= long_release_valid_in;
         long_fired_ff         <= long_fired_in;
      end
   end

   // two-entry result queue, head in slot0
   assign count_after_pop = count_ff - {1'b0, pop};
   assign count_in        = count_after_pop + {1'b0, push};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && (count_after_pop == 2'd0)) begin
         slot0_ff <= result;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
      if (push && (count_after_pop != 2'd0)) begin
         slot1_ff <= result;
      end
   end

   assign req_ready          = (count_ff != 2'd2);
   assign rsp_valid          = (count_ff != 2'd0);
   assign rsp_gesture        = slot0_ff.gesture;
   assign rsp_stable_pressed = slot0_ff.stable_pressed;

endmodule

// ===== rtl/bdgd_checker.sv =====
// Port-level checker for the button debounce / gesture detector, with its bind.
// Depends on bdgd_pkg for the gesture codes.
module bdgd_checker
   import bdgd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_gesture,
   input logic       rsp_stable_pressed
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   // a poll taken into an empty queue shows up on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> rsp_valid)
      else $error("result missing after poll transfer");

   // a poll taken while one result waits fills the queue
   a_queue_full: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid && !rsp_ready |=> !req_ready)
      else $error("req_ready high with two results pending");

   // long press is reported only while held; clicks and secret gestures only on release
   a_gesture_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_gesture == GESTURE_LONG) ? rsp_stable_pressed :
          ((rsp_gesture == GESTURE_CLICK) || (rsp_gesture == GESTURE_SECRET))
             ? !rsp_stable_pressed : 1'b1))
      else $error("gesture inconsistent with debounced level");

endmodule

bind button_debounce_gesture_detector bdgd_checker u_bdgd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_gesture        (rsp_gesture),
   .rsp_stable_pressed (rsp_stable_pressed)
);
